### hdl/cpu_6502_subset_core_unit_assert.svh
// Assertion macros for the subset core.
`ifndef CPU_6502_SUBSET_CORE_UNIT_ASSERT_SVH
`define CPU_6502_SUBSET_CORE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CORE_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("core check failed");
// Next-cycle implication.
`define CORE_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("core check failed");
`endif

### hdl/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg
// Phase codes, opcodes, reset constants and the state and bus types of the subset core.
// ----------------------------------------------------------------------------
package c6502_pkg;

    localparam logic [3:0] PH_VEC_LO  = 4'd0;
    localparam logic [3:0] PH_VEC_HI  = 4'd1;
    localparam logic [3:0] PH_FETCH   = 4'd2;
    localparam logic [3:0] PH_OP1     = 4'd3;
    localparam logic [3:0] PH_JMP_HI  = 4'd4;
    localparam logic [3:0] PH_JSR_PCL = 4'd5;
    localparam logic [3:0] PH_JSR_HI  = 4'd6;
    localparam logic [3:0] PH_JSR_TGT = 4'd7;
    localparam logic [3:0] PH_BIT_RD  = 4'd8;
    localparam logic [3:0] PH_PULL    = 4'd9;
    localparam logic [3:0] PH_RTS_HI  = 4'd10;
    localparam logic [3:0] PH_WDONE   = 4'd11;

    localparam logic [7:0] OP_LDA = 8'hA9, OP_LDX = 8'hA2, OP_LDY = 8'hA0;
    localparam logic [7:0] OP_ADC = 8'h69, OP_AND = 8'h29, OP_ORA = 8'h09;
    localparam logic [7:0] OP_EOR = 8'h49, OP_CMP = 8'hC9, OP_CPX = 8'hE0;
    localparam logic [7:0] OP_CPY = 8'hC0, OP_STA = 8'h85, OP_STX = 8'h86;
    localparam logic [7:0] OP_BIT = 8'h24, OP_JMP = 8'h4C, OP_JSR = 8'h20;
    localparam logic [7:0] OP_RTS = 8'h60, OP_PLA = 8'h68, OP_PLP = 8'h28;
    localparam logic [7:0] OP_PHA = 8'h48, OP_PHP = 8'h08, OP_CLC = 8'h18;
    localparam logic [7:0] OP_SEC = 8'h38, OP_SEI = 8'h78, OP_CLD = 8'hD8;
    localparam logic [7:0] OP_SED = 8'hF8, OP_CLV = 8'hB8, OP_NOP = 8'hEA;

    localparam logic [15:0] RESET_VECTOR = 16'hFFFC;
    localparam logic [7:0]  FLAG_RESET   = 8'h24;
    localparam logic [7:0]  STACK_RESET  = 8'hFD;
    localparam logic [7:0]  STACK_PAGE   = 8'h01;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  p;
        logic [7:0]  s;
        logic [15:0] pc;
        logic [7:0]  op;
        logic [7:0]  lo;
        logic [3:0]  phase;
        logic        halt;
    } core_state_t;

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wd;
        logic        fetch;
    } bus_req_t;

endpackage

### hdl/c6502_step.sv
// ----------------------------------------------------------------------------
// c6502_step
// One bus cycle of the core: next state and next access from the read byte.
// ----------------------------------------------------------------------------
module c6502_step
    import c6502_pkg::*;
(
    input  core_state_t cur,
    input  logic [7:0]  rd,
    output core_state_t nxt,
    output bus_req_t    req
);

    function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
        nz = (p & 8'h7D) | (v & 8'h80) | {6'd0, (v == 8'd0), 1'b0};
    endfunction

    function automatic logic [7:0] cmpf(input logic [7:0] p, input logic [7:0] r,
                                        input logic [7:0] m);
        logic [7:0] q;
        q = {p[7:1], (r >= m)};
        cmpf = nz(q, r - m);
    endfunction

    logic [8:0]  sum;
    logic [7:0]  sres;
    logic [15:0] pc1;
    logic [15:0] stk;
    logic [7:0]  bmask;
    logic        btaken;
    logic        has_opr;

    always_comb begin
        sum    = {1'b0, cur.acc} + {1'b0, rd} + {8'd0, cur.p[0]};
        sres   = sum[7:0];
        pc1    = cur.pc + 16'd1;
        stk    = {STACK_PAGE, cur.s};
        unique case (cur.op[7:6])
            2'd0: bmask = 8'h80;
            2'd1: bmask = 8'h40;
            2'd2: bmask = 8'h01;
            default: bmask = 8'h02;
        endcase
        btaken = (cur.op[5] == ((cur.p & bmask) != 8'd0));
        unique case (rd)
            OP_LDA, OP_LDX, OP_LDY, OP_ADC, OP_AND, OP_ORA, OP_EOR, OP_CMP,
            OP_CPX, OP_CPY, OP_STA, OP_STX, OP_BIT, OP_JMP, OP_JSR: has_opr = 1'b1;
            default: has_opr = (rd[4:0] == 5'h10);
        endcase

        nxt = cur;
        req = '{addr: cur.pc, wr: 1'b0, wd: 8'd0, fetch: 1'b1};
        nxt.phase = PH_FETCH;
        if (!cur.halt) begin
            unique case (cur.phase)
                PH_VEC_LO: begin
                    nxt.lo = rd;
                    req.addr = RESET_VECTOR + 16'd1;
                    req.fetch = 1'b0;
                    nxt.phase = PH_VEC_HI;
                end
                PH_VEC_HI, PH_JMP_HI, PH_JSR_TGT: begin
                    nxt.pc = {rd, cur.lo};
                    req.addr = {rd, cur.lo};
                end
                PH_OP1: begin
                    nxt.pc = pc1;
                    req.addr = pc1;
                    unique case (cur.op)
                        OP_LDA: begin nxt.acc = rd; nxt.p = nz(cur.p, rd); end
                        OP_LDX: begin nxt.x = rd; nxt.p = nz(cur.p, rd); end
                        OP_LDY: begin nxt.y = rd; nxt.p = nz(cur.p, rd); end
                        OP_ADC: begin
                            nxt.acc = sres;
                            nxt.p = nz({cur.p[7],
                                ((cur.acc[7] ^ sres[7]) & (rd[7] ^ sres[7])),
                                cur.p[5:1], sum[8]}, sres);
                        end
                        OP_AND: begin
                            nxt.acc = cur.acc & rd; nxt.p = nz(cur.p, cur.acc & rd);
                        end
                        OP_ORA: begin
                            nxt.acc = cur.acc | rd; nxt.p = nz(cur.p, cur.acc | rd);
                        end
                        OP_EOR: begin
                            nxt.acc = cur.acc ^ rd; nxt.p = nz(cur.p, cur.acc ^ rd);
                        end
                        OP_CMP: nxt.p = cmpf(cur.p, cur.acc, rd);
                        OP_CPX: nxt.p = cmpf(cur.p, cur.x, rd);
                        OP_CPY: nxt.p = cmpf(cur.p, cur.y, rd);
                        OP_STA, OP_STX: begin
                            req.addr = {8'd0, rd};
                            req.wr = 1'b1;
                            req.fetch = 1'b0;
                            req.wd = (cur.op == OP_STA) ? cur.acc : cur.x;
                            nxt.phase = PH_WDONE;
                        end
                        OP_BIT: begin
                            req.addr = {8'd0, rd};
                            req.fetch = 1'b0;
                            nxt.phase = PH_BIT_RD;
                        end
                        OP_JMP: begin
                            nxt.lo = rd; req.fetch = 1'b0; nxt.phase = PH_JMP_HI;
                        end
                        OP_JSR: begin
                            nxt.lo = rd;
                            req.addr = stk;
                            req.wr = 1'b1;
                            req.fetch = 1'b0;
                            req.wd = pc1[15:8];
                            nxt.s = cur.s - 8'd1;
                            nxt.phase = PH_JSR_PCL;
                        end
                        default: begin
                            if (cur.op[4:0] == 5'h10 && btaken) begin
                                nxt.pc = pc1 + {{8{rd[7]}}, rd};
                                req.addr = pc1 + {{8{rd[7]}}, rd};
                            end
                        end
                    endcase
                end
                PH_JSR_PCL: begin
                    req.addr = stk;
                    req.wr = 1'b1;
                    req.fetch = 1'b0;
                    req.wd = cur.pc[7:0];
                    nxt.s = cur.s - 8'd1;
                    nxt.phase = PH_JSR_HI;
                end
                PH_JSR_HI: begin
                    req.fetch = 1'b0;
                    nxt.phase = PH_JSR_TGT;
                end
                PH_BIT_RD: begin
                    nxt.p = (cur.p & 8'h3D) | (rd & 8'hC0)
                          | {6'd0, ((cur.acc & rd) == 8'd0), 1'b0};
                end
                PH_PULL: begin
                    if (cur.op == OP_RTS) begin
                        nxt.lo = rd;
                        nxt.s = cur.s + 8'd1;
                        req.addr = {STACK_PAGE, cur.s + 8'd1};
                        req.fetch = 1'b0;
                        nxt.phase = PH_RTS_HI;
                    end else if (cur.op == OP_PLA) begin
                        nxt.acc = rd; nxt.p = nz(cur.p, rd);
                    end else begin
                        nxt.p = (rd & 8'hCF) | (cur.p & 8'h30);
                    end
                end
                PH_RTS_HI: begin
                    nxt.pc = {rd, cur.lo} + 16'd1;
                    req.addr = {rd, cur.lo} + 16'd1;
                end
                PH_WDONE: ;
                default: begin
                    nxt.op = rd;
                    nxt.pc = pc1;
                    req.addr = pc1;
                    if (has_opr) begin
                        req.fetch = 1'b0;
                        nxt.phase = PH_OP1;
                    end else begin
                        unique case (rd)
                            OP_RTS, OP_PLA, OP_PLP: begin
                                nxt.s = cur.s + 8'd1;
                                req.addr = {STACK_PAGE, cur.s + 8'd1};
                                req.fetch = 1'b0;
                                nxt.phase = PH_PULL;
                            end
                            OP_PHA, OP_PHP: begin
                                req.addr = stk;
                                req.wr = 1'b1;
                                req.fetch = 1'b0;
                                req.wd = (rd == OP_PHA) ? cur.acc : (cur.p | 8'h10);
                                nxt.s = cur.s - 8'd1;
                                nxt.phase = PH_WDONE;
                            end
                            OP_CLC: nxt.p = cur.p & 8'hFE;
                            OP_SEC: nxt.p = cur.p | 8'h01;
                            OP_SEI: nxt.p = cur.p | 8'h04;
                            OP_CLD: nxt.p = cur.p & 8'hF7;
                            OP_SED: nxt.p = cur.p | 8'h08;
                            OP_CLV: nxt.p = cur.p & 8'hBF;
                            OP_NOP: ;
                            default: nxt.halt = 1'b1;
                        endcase
                    end
                end
            endcase
        end else begin
            nxt.phase = cur.phase;
        end
        if (nxt.halt) begin
            req = '0;
        end
    end

endmodule

### hdl/cpu_6502_subset_core_unit.sv
// ----------------------------------------------------------------------------
// cpu_6502_subset_core_unit
// Bus-cycle core for a subset of the 6502 instruction set.
// ----------------------------------------------------------------------------
// Input stream s_*: each request is the byte answered for the pending bus
// access (ignored after a write). After reset the pending access is a read
// of FFFC, which is not announced.
// Output stream m_*: one request per input, naming the next access and the
// register values after the cycle.
// A result is registered as its input is taken. Throughput: one input
// per cycle while the receiver does not stall; the combinational step
// logic plus the output register set that figure. s_tready stays high
// while the output register is empty or being taken in the same cycle.
// Reset (aresetn low, synchronous) loads A=X=Y=0, P=24h, S=FDh and empties
// the output register. When the receiver stalls, the result holds and no
// new input is taken. An unsupported opcode halts the core for good: all
// later results show a zero access and frozen registers.
// ----------------------------------------------------------------------------
module cpu_6502_subset_core_unit
    import c6502_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] read_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // bus_address[15:0], is_write[16], write_byte[24:17],
                                   // opcode_fetch[25], halted[26], accumulator[34:27],
                                   // index_x[42:35], index_y[50:43],
                                   // status_flags[58:51], stack_index[66:59], zero[71:67]
);

    core_state_t state_reg, state_next;
    bus_req_t    req;
    logic [66:0] out_reg;
    logic        vld_reg;
    logic        take;

    assign s_tready = !vld_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    c6502_step u_step (.cur(state_reg), .rd(s_tdata), .nxt(state_next), .req(req));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{acc: 8'd0, x: 8'd0, y: 8'd0, p: FLAG_RESET, s: STACK_RESET,
                           pc: 16'd0, op: 8'd0, lo: 8'd0, phase: PH_VEC_LO, halt: 1'b0};
            vld_reg <= 1'b0;
        end else begin
            if (take) begin
                state_reg <= state_next;
                vld_reg   <= 1'b1;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= {state_next.s, state_next.p, state_next.y, state_next.x,
                        state_next.acc, state_next.halt, req.fetch, req.wd, req.wr,
                        req.addr};
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule

### hdl/c6502_checker.sv
// ----------------------------------------------------------------------------
// c6502_checker
// Port-level checks of the subset core, bound to the top level.
// ----------------------------------------------------------------------------
`include "cpu_6502_subset_core_unit_assert.svh"
module c6502_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    `CORE_ASSERT_IMP(a_ready, aclk, aresetn, !m_tvalid, s_tready)
    `CORE_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CORE_ASSERT_NXT(a_take_out, aclk, aresetn, s_tvalid && s_tready, m_tvalid)
    `CORE_ASSERT_IMP(a_halt_quiet, aclk, aresetn, m_tvalid && m_tdata[26], m_tdata[25:0] == 26'd0)
    `CORE_ASSERT_IMP(a_wr_nofetch, aclk, aresetn, m_tvalid && m_tdata[16], !m_tdata[25])
endmodule

bind cpu_6502_subset_core_unit c6502_checker u_chk (.*);
